// ===== hdl/gfa_pkg.sv =====
// ----------------------------------------------------------------------------
// gfa_pkg
// Shared types and constants of the Galois field arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gfa_pkg;

  localparam int ELEM_W  = 8;
  localparam int COUNT_W = 16;
  localparam int POLY_W  = 8;
  localparam logic [POLY_W-1:0] POLY_RESET = 8'd29;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_SUB      = 3'd1,
    OP_MUL      = 3'd2,
    OP_DIV      = 3'd3,
    OP_NEG      = 3'd4,
    OP_INV      = 3'd5,
    OP_MULTIPLE = 3'd6,
    OP_POWER    = 3'd7
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [ELEM_W-1:0]  operand_a;
    logic [ELEM_W-1:0]  operand_b;
    logic [COUNT_W-1:0] count;
  } request_t;

  typedef struct packed {
    logic [ELEM_W-1:0] result;
    logic              error;
  } response_t;

  typedef struct packed {
    logic valid;
    op_t  operation;
    logic singular;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/gfa_mul.sv =====
// ----------------------------------------------------------------------------
// gfa_mul
// Combinational GF(2^M) multiplier, shift-and-add with polynomial reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module gfa_mul #(
  parameter int FIELD_BITS = 8
) (
  input  wire logic [FIELD_BITS-1:0] a,
  input  wire logic [FIELD_BITS-1:0] b,
  input  wire logic [FIELD_BITS-1:0] poly,
  output logic      [FIELD_BITS-1:0] p
);

  always_comb begin
    logic [FIELD_BITS-1:0] acc;
    acc = '0;
    for (int i = FIELD_BITS - 1; i >= 0; i--) begin
      acc = {acc[FIELD_BITS-2:0], 1'b0} ^ (acc[FIELD_BITS-1] ? poly : '0);
      if (b[i]) begin
        acc = acc ^ a;
      end
    end
    p = acc;
  end

endmodule

`default_nettype wire

// ===== hdl/gfa_stage.sv =====
// ----------------------------------------------------------------------------
// gfa_stage
// One pipeline step, registered: a square-and-multiply step of the power chain
// and, if STEP < FIELD_BITS, one Gauss-Jordan column of the inversion system.
// ----------------------------------------------------------------------------
`default_nettype none

module gfa_stage #(
  parameter int FIELD_BITS = 8,
  parameter int STEP       = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [FIELD_BITS-1:0]        poly,
  input  wire gfa_pkg::ctl_t                ctl_in,
  input  wire logic [FIELD_BITS-1:0]        a_in,
  input  wire logic [gfa_pkg::COUNT_W-1:0]  count_in,
  input  wire logic [FIELD_BITS-1:0]        base_in,
  input  wire logic [FIELD_BITS-1:0]        acc_in,
  input  wire logic [FIELD_BITS:0]          rows_in [FIELD_BITS],
  output gfa_pkg::ctl_t                     ctl_out,
  output logic      [FIELD_BITS-1:0]        a_out,
  output logic      [gfa_pkg::COUNT_W-1:0]  count_out,
  output logic      [FIELD_BITS-1:0]        base_out,
  output logic      [FIELD_BITS-1:0]        acc_out,
  output logic      [FIELD_BITS:0]          rows_out [FIELD_BITS]
);

  logic [FIELD_BITS-1:0] prod;
  logic [FIELD_BITS-1:0] square;
  logic [FIELD_BITS:0]   rows_next [FIELD_BITS];
  logic                  singular_next;

  gfa_mul #(.FIELD_BITS(FIELD_BITS)) u_mul (
    .a(acc_in), .b(base_in), .poly(poly), .p(prod)
  );

  gfa_mul #(.FIELD_BITS(FIELD_BITS)) u_sqr (
    .a(base_in), .b(base_in), .poly(poly), .p(square)
  );

  generate
    if (STEP < FIELD_BITS) begin : g_elim
      always_comb begin
        logic                  found;
        logic [FIELD_BITS:0]   prow;
        logic [FIELD_BITS:0]   tmp [FIELD_BITS];
        int                    pidx;
        found = 1'b0;
        pidx  = STEP;
        for (int r = STEP; r < FIELD_BITS; r++) begin
          if (!found && rows_in[r][STEP]) begin
            found = 1'b1;
            pidx  = r;
          end
        end
        prow = rows_in[pidx];
        tmp  = rows_in;
        tmp[pidx] = rows_in[STEP];
        tmp[STEP] = prow;
        for (int r = 0; r < FIELD_BITS; r++) begin
          if (r != STEP && found && tmp[r][STEP]) begin
            tmp[r] = tmp[r] ^ prow;
          end
        end
        rows_next     = tmp;
        singular_next = ctl_in.singular | ~found;
      end
    end else begin : g_pass
      always_comb begin
        rows_next     = rows_in;
        singular_next = ctl_in.singular;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.operation <= ctl_in.operation;
    ctl_out.singular  <= singular_next;
    a_out     <= a_in;
    count_out <= count_in;
    base_out  <= square;
    acc_out   <= count_in[STEP] ? prod : acc_in;
    rows_out  <= rows_next;
  end

endmodule

`default_nettype wire

// ===== hdl/galois_field_alu.sv =====
// ----------------------------------------------------------------------------
// galois_field_alu
// Pipelined GF(2^M) arithmetic unit with a programmable reduction polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and raise start; the transaction is taken at a rising edge
//   with start high and busy low. busy stays low, so a transaction may be
//   issued on every cycle. The response appears with done high for exactly
//   one cycle, in issue order. Throughput is one transaction per cycle.
//   The path runs through an input register, the 16-step square-and-multiply
//   chain (one exponent bit per stage), which also carries the per-column
//   Gauss-Jordan elimination for the inverse, and a multiply-and-select stage.
//   poly_we with poly_data writes the reduction polynomial; write it only
//   while no transaction is in flight.
//   Reset clears the pipeline valid bits and loads the polynomial with 29.
//   The receiver cannot stall: each response must be taken as it appears.
// ----------------------------------------------------------------------------
`default_nettype none

module galois_field_alu #(
  parameter int FIELD_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire gfa_pkg::request_t           request,
  output logic                             done,
  output gfa_pkg::response_t               response,
  input  wire logic                        poly_we,
  input  wire logic [gfa_pkg::POLY_W-1:0]  poly_data
);

  localparam int NSTEP = gfa_pkg::COUNT_W;
  localparam int PW    = (FIELD_BITS < gfa_pkg::ELEM_W) ? FIELD_BITS : gfa_pkg::ELEM_W;
  localparam int QW    = (FIELD_BITS < gfa_pkg::POLY_W) ? FIELD_BITS : gfa_pkg::POLY_W;

  logic [gfa_pkg::POLY_W-1:0] poly_reg;
  logic [FIELD_BITS-1:0]      poly;
  logic                       in_valid;
  gfa_pkg::request_t          in_req;

  gfa_pkg::ctl_t               ctl_s   [NSTEP+1];
  logic [FIELD_BITS-1:0]       a_s     [NSTEP+1];
  logic [gfa_pkg::COUNT_W-1:0] count_s [NSTEP+1];
  logic [FIELD_BITS-1:0]       base_s  [NSTEP+1];
  logic [FIELD_BITS-1:0]       acc_s   [NSTEP+1];
  logic [FIELD_BITS:0]         rows_s  [NSTEP+1][FIELD_BITS];

  logic [FIELD_BITS-1:0] b_m;
  logic [FIELD_BITS-1:0] col [FIELD_BITS];
  logic [FIELD_BITS-1:0] inv;
  logic [FIELD_BITS-1:0] quot;
  logic [FIELD_BITS-1:0] elem;
  logic                  err;

  assign busy = 1'b0;
  assign poly = FIELD_BITS'(poly_reg[QW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_reg <= gfa_pkg::POLY_RESET;
      in_valid <= 1'b0;
    end else begin
      if (poly_we) begin
        poly_reg <= poly_data;
      end
      in_valid <= start & ~busy;
    end
    in_req <= request;
  end

  always_comb begin
    b_m              = FIELD_BITS'(in_req.operand_b[PW-1:0]);
    a_s[0]           = FIELD_BITS'(in_req.operand_a[PW-1:0]);
    count_s[0]       = in_req.count;
    base_s[0]        = a_s[0];
    acc_s[0]         = FIELD_BITS'(1);
    ctl_s[0].valid     = in_valid;
    ctl_s[0].operation = in_req.operation;
    ctl_s[0].singular  = 1'b0;
    col[0] = (in_req.operation == gfa_pkg::OP_DIV) ? b_m : a_s[0];
    for (int j = 1; j < FIELD_BITS; j++) begin
      col[j] = {col[j-1][FIELD_BITS-2:0], 1'b0} ^ (col[j-1][FIELD_BITS-1] ? poly : '0);
    end
    for (int r = 0; r < FIELD_BITS; r++) begin
      for (int j = 0; j < FIELD_BITS; j++) begin
        rows_s[0][r][j] = col[j][r];
      end
      rows_s[0][r][FIELD_BITS] = (r == 0);
    end
  end

  generate
    for (genvar i = 0; i < NSTEP; i++) begin : g_stage
      gfa_stage #(.FIELD_BITS(FIELD_BITS), .STEP(i)) u_stage (
        .clk       (clk),
        .rst       (rst),
        .poly      (poly),
        .ctl_in    (ctl_s[i]),
        .a_in      (a_s[i]),
        .count_in  (count_s[i]),
        .base_in   (base_s[i]),
        .acc_in    (acc_s[i]),
        .rows_in   (rows_s[i]),
        .ctl_out   (ctl_s[i+1]),
        .a_out     (a_s[i+1]),
        .count_out (count_s[i+1]),
        .base_out  (base_s[i+1]),
        .acc_out   (acc_s[i+1]),
        .rows_out  (rows_s[i+1])
      );
    end
  endgenerate

  always_comb begin
    for (int k = 0; k < FIELD_BITS; k++) begin
      inv[k] = rows_s[NSTEP][k][FIELD_BITS];
    end
  end

  gfa_mul #(.FIELD_BITS(FIELD_BITS)) u_div (
    .a(a_s[NSTEP]), .b(inv), .poly(poly), .p(quot)
  );

  always_comb begin
    err  = 1'b0;
    elem = '0;
    unique case (ctl_s[NSTEP].operation)
      gfa_pkg::OP_ADD, gfa_pkg::OP_SUB, gfa_pkg::OP_MUL, gfa_pkg::OP_NEG: begin
        elem = acc_s[NSTEP];
      end
      gfa_pkg::OP_DIV: begin
        err  = ctl_s[NSTEP].singular;
        elem = err ? '0 : quot;
      end
      gfa_pkg::OP_INV: begin
        err  = ctl_s[NSTEP].singular;
        elem = err ? '0 : inv;
      end
      gfa_pkg::OP_MULTIPLE: begin
        elem = count_s[NSTEP][0] ? a_s[NSTEP] : '0;
      end
      gfa_pkg::OP_POWER: begin
        elem = acc_s[NSTEP];
      end
    endcase
  end

  // carry simple results beside the power chain
  logic [FIELD_BITS-1:0] simple_in;
  logic [FIELD_BITS-1:0] simple_res [NSTEP];
  logic [FIELD_BITS-1:0] simple_mul;

  gfa_mul #(.FIELD_BITS(FIELD_BITS)) u_simple (
    .a(a_s[0]), .b(b_m), .poly(poly), .p(simple_mul)
  );

  always_comb begin
    simple_in = '0;
    unique case (in_req.operation)
      gfa_pkg::OP_ADD, gfa_pkg::OP_SUB: simple_in = a_s[0] ^ b_m;
      gfa_pkg::OP_MUL:                  simple_in = simple_mul;
      gfa_pkg::OP_NEG:                  simple_in = a_s[0];
      gfa_pkg::OP_DIV, gfa_pkg::OP_INV, gfa_pkg::OP_MULTIPLE,
      gfa_pkg::OP_POWER:                simple_in = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    simple_res[0] <= simple_in;
    for (int i = 1; i < NSTEP; i++) begin
      simple_res[i] <= simple_res[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_s[NSTEP].valid;
    end
    response.error <= err;
    if (ctl_s[NSTEP].operation == gfa_pkg::OP_ADD || ctl_s[NSTEP].operation == gfa_pkg::OP_SUB
        || ctl_s[NSTEP].operation == gfa_pkg::OP_MUL
        || ctl_s[NSTEP].operation == gfa_pkg::OP_NEG) begin
      response.result <= gfa_pkg::ELEM_W'(simple_res[NSTEP-1][PW-1:0]);
    end else begin
      response.result <= gfa_pkg::ELEM_W'(elem[PW-1:0]);
    end
  end

endmodule

`default_nettype wire
